// ===== hdl/nht_pkg.sv =====
// Shared constants, codes and types for the node heartbeat table.
// No dependencies; imported by every other file of the block but nht_ram.
`default_nettype none

package nht_pkg;

  // Table depth and derived widths
  localparam int MAX_NODES = 64;
  localparam int IDX_W     = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int CNT_W     = $clog2(MAX_NODES + 1);

  // Fixed field widths of the ports
  localparam int ID_W   = 32;
  localparam int SLOT_W = 6;
  localparam int NCNT_W = 7;
  localparam int SUM_W  = 48;
  localparam int LINK_W = 8;

  // Outcome codes
  localparam logic [1:0] OUTCOME_DUP  = 2'd0;
  localparam logic [1:0] OUTCOME_UPD  = 2'd1;
  localparam logic [1:0] OUTCOME_NEW  = 2'd2;
  localparam logic [1:0] OUTCOME_FULL = 2'd3;

  // One stored table entry
  typedef struct packed {
    logic [ID_W-1:0] node;
    logic [ID_W-1:0] pkt;
    logic [ID_W-1:0] beats;
  } nht_entry_t;

  localparam int ENTRY_W = $bits(nht_entry_t);

  // Controller to datapath
  typedef struct packed {
    logic load;    // capture the incoming report, restart the scan
    logic scan;    // walk the table one entry a cycle
    logic commit;  // resolve, write back, present the result
  } nht_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic hit;       // compared entry matches the node id
    logic scan_end;  // all valid entries compared, no match
    logic out_free;  // result register can take a new result
  } nht_status_t;

endpackage

`default_nettype wire

// ===== hdl/nht_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module nht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic                                   re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/nht_ctrl.sv =====
// Sequencing state machine for the heartbeat table: accept, scan, commit.
// Depends on nht_pkg.
`default_nettype none

module nht_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  output nht_pkg::nht_cmd_t        cmd,
  input  wire nht_pkg::nht_status_t status
);

  import nht_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_COMMIT = 2'd2;

  logic [1:0] state, state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (status.hit || status.scan_end) begin
          state_next = S_COMMIT;
        end
      end
      S_COMMIT: begin
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != S_IDLE);

endmodule

`default_nettype wire

// ===== hdl/nht_datapath.sv =====
// Datapath: report registers, scan pointer, entry RAM, counters, result register.
// Depends on nht_pkg and nht_ram.
`default_nettype none

module nht_datapath (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire nht_pkg::nht_cmd_t       cmd,
  output nht_pkg::nht_status_t         status,
  input  wire logic [31:0]             node_id,
  input  wire logic [31:0]             packet_id,
  input  wire logic signed [7:0]       rssi_dbm,
  input  wire logic signed [7:0]       snr_qdb,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic [1:0]                   outcome,
  output logic [5:0]                   slot,
  output logic [31:0]                  beat_count,
  output logic [6:0]                   node_count,
  output logic [31:0]                  packets_total,
  output logic [31:0]                  dups_total,
  output logic signed [47:0]           rssi_sum,
  output logic signed [47:0]           snr_sum
);

  import nht_pkg::*;

  // Captured report
  logic [ID_W-1:0]   node_r, pkt_r;
  logic [LINK_W-1:0] rssi_r, snr_r;

  // Scan state
  logic [CNT_W-1:0] scan_idx;
  logic             cmp_valid;
  logic [IDX_W-1:0] cmp_idx;
  logic             found;
  logic [IDX_W-1:0] found_idx;

  // Running state
  logic [CNT_W-1:0] used;
  logic [ID_W-1:0]  accepted_count, duplicate_count;
  logic [SUM_W-1:0] rssi_total, snr_total;

  // RAM interface
  nht_entry_t       rd_entry, wr_entry;
  logic             re, we;
  logic [IDX_W-1:0] waddr;

  // Commit decode
  logic             hit, is_dup, room;
  logic [1:0]       outcome_next;
  logic [IDX_W-1:0] slot_idx;
  logic [ID_W-1:0]  beats_next;
  logic [SUM_W-1:0] rssi_ext, snr_ext;

  assign hit = cmp_valid && (rd_entry.node == node_r);
  assign re  = cmd.scan && (scan_idx < used) && !hit;

  // cmp_valid is only set by a scan read, so hit and scan_end are driven from registers alone
  assign status.hit      = hit;
  assign status.scan_end = (scan_idx == used) && !hit;
  assign status.out_free = !out_valid || !out_stall;

  // rd_entry still holds the matched entry here: reads stop on a hit
  assign is_dup = found && (rd_entry.pkt == pkt_r) && (pkt_r != '0);
  assign room   = (used < CNT_W'(MAX_NODES));

  assign rssi_ext = {{(SUM_W-LINK_W){rssi_r[LINK_W-1]}}, rssi_r};
  assign snr_ext  = {{(SUM_W-LINK_W){snr_r[LINK_W-1]}}, snr_r};

  always_comb begin
    outcome_next = OUTCOME_FULL;
    slot_idx     = '0;
    beats_next   = '0;
    we           = 1'b0;
    waddr        = found_idx;
    if (is_dup) begin
      outcome_next = OUTCOME_DUP;
      slot_idx     = found_idx;
      beats_next   = rd_entry.beats;
    end else if (found) begin
      outcome_next = OUTCOME_UPD;
      slot_idx     = found_idx;
      beats_next   = rd_entry.beats + 1'b1;
      we           = cmd.commit;
    end else if (room) begin
      outcome_next = OUTCOME_NEW;
      slot_idx     = used[IDX_W-1:0];
      beats_next   = ID_W'(1);
      waddr        = used[IDX_W-1:0];
      we           = cmd.commit;
    end
    wr_entry.node  = node_r;
    wr_entry.pkt   = pkt_r;
    wr_entry.beats = beats_next;
  end

  nht_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_NODES)
  ) u_entry_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wr_entry),
    .re    (re),
    .raddr (scan_idx[IDX_W-1:0]),
    .rdata (rd_entry)
  );

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      node_r <= node_id;
      pkt_r  <= packet_id;
      rssi_r <= rssi_dbm;
      snr_r  <= snr_qdb;
    end
    if (re) begin
      cmp_idx <= scan_idx[IDX_W-1:0];
    end
    if (status.hit) begin
      found_idx <= cmp_idx;
    end
    if (cmd.commit) begin
      outcome    <= outcome_next;
      slot       <= SLOT_W'(slot_idx);
      beat_count <= beats_next;
    end
  end

  // Control and running state
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx        <= '0;
      cmp_valid       <= 1'b0;
      found           <= 1'b0;
      used            <= '0;
      accepted_count  <= '0;
      duplicate_count <= '0;
      rssi_total      <= '0;
      snr_total       <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (cmd.load) begin
        scan_idx  <= '0;
        cmp_valid <= 1'b0;
        found     <= 1'b0;
      end else begin
        cmp_valid <= re;
        if (re) begin
          scan_idx <= scan_idx + 1'b1;
        end
        if (status.hit) begin
          found <= 1'b1;
        end
      end

      if (cmd.commit) begin
        if (is_dup) begin
          duplicate_count <= duplicate_count + 1'b1;
        end else if (found || room) begin
          accepted_count <= accepted_count + 1'b1;
          rssi_total     <= rssi_total + rssi_ext;
          snr_total      <= snr_total + snr_ext;
          if (!found) begin
            used <= used + 1'b1;
          end
        end
      end

      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Totals are stable while a result waits: the next commit needs the slot free
  assign node_count    = NCNT_W'(used);
  assign packets_total = accepted_count;
  assign dups_total    = duplicate_count;
  assign rssi_sum      = rssi_total;
  assign snr_sum       = snr_total;

endmodule

`default_nettype wire

// ===== hdl/node_heartbeat_table.sv =====
// Top level of the node heartbeat table: controller plus datapath.
// Depends on nht_pkg, nht_ctrl, nht_datapath (and through it nht_ram).
//
// Heartbeat registry for sensor nodes. Each report transfer on the input
// channel looks up its node id among the occupied table entries, in index
// order, one entry per cycle out of a single-port-read RAM. A match with an
// equal, nonzero packet id is a duplicate and only bumps the duplicate
// counter; any other match refreshes the entry and increments its beat
// count; an unknown node takes the next free entry with a count of one, or
// is refused with the table-full outcome (slot and count zero) once all
// MAX_NODES entries are taken. Non-duplicate accepted reports bump the
// packet total and add RSSI and quarter-dB SNR into 48-bit wrapping sums.
// Every report gives exactly one result transfer.
// Sequence: an unknown node is compared against every occupied entry, with
// the RAM read and compare pipelined, and then committed; a hit on an entry
// ends the scan early. The controller returns to idle after the commit, so
// a new report is taken only once the previous one has committed, and the
// commit itself waits while a stalled result holds the output register. The
// scan of the entry RAM sets how often reports can be taken. Input stall is
// high from the transfer until commit; a result waiting in the output
// register does not hold off the next report, only its commit.
// Entries are never freed except by reset; there is no clearing pass, the
// fill count alone marks which entries are valid.
`default_nettype none

module node_heartbeat_table (
  input  wire logic               clk,
  input  wire logic               rst,
  // report channel
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [31:0]        node_id,
  input  wire logic [31:0]        packet_id,
  input  wire logic signed [7:0]  rssi_dbm,
  input  wire logic signed [7:0]  snr_qdb,
  input  wire logic [31:0]        time_ms,
  input  wire logic [7:0]         fw_major,
  input  wire logic [7:0]         fw_minor,
  input  wire logic [7:0]         fw_patch,
  input  wire logic [7:0]         battery,
  // result channel
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [1:0]              outcome,
  output logic [5:0]              slot,
  output logic [31:0]             beat_count,
  output logic [6:0]              node_count,
  output logic [31:0]             packets_total,
  output logic [31:0]             dups_total,
  output logic signed [47:0]      rssi_sum,
  output logic signed [47:0]      snr_sum
);

  import nht_pkg::*;

  nht_cmd_t    cmd;
  nht_status_t status;

  // Time stamp, firmware and battery fields carry no weight on any result;
  // they are accepted with the report and not stored.
  logic unused_fields;
  assign unused_fields = ^{time_ms, fw_major, fw_minor, fw_patch, battery};

  nht_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .status   (status)
  );

  nht_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .node_id       (node_id),
    .packet_id     (packet_id),
    .rssi_dbm      (rssi_dbm),
    .snr_qdb       (snr_qdb),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .outcome       (outcome),
    .slot          (slot),
    .beat_count    (beat_count),
    .node_count    (node_count),
    .packets_total (packets_total),
    .dups_total    (dups_total),
    .rssi_sum      (rssi_sum),
    .snr_sum       (snr_sum)
  );

endmodule

`default_nettype wire

// ===== hdl/nht_checker.sv =====
// Port-level checker for the node heartbeat table, bound to the top level.
// Depends on nht_pkg.
`default_nettype none

module nht_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_valid,
  input wire logic              in_stall,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire logic [1:0]        outcome,
  input wire logic [5:0]        slot,
  input wire logic [31:0]       beat_count,
  input wire logic [6:0]        node_count
);

  import nht_pkg::*;

  // A pending result is held until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // The block is busy right after taking a report
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("report taken while previous one in progress");

  // A refused node reports slot and count zero, with a full table
  a_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && outcome == OUTCOME_FULL |->
      slot == '0 && beat_count == '0 && node_count == NCNT_W'(MAX_NODES))
    else $error("table-full result inconsistent");

  // A new node starts at count one and occupies the last filled entry
  a_new: assert property (@(posedge clk) disable iff (rst)
    out_valid && outcome == OUTCOME_NEW |->
      beat_count == 32'd1 && node_count == NCNT_W'(slot) + 1'b1)
    else $error("new-node result inconsistent");

endmodule

bind node_heartbeat_table nht_checker u_nht_checker (.*);

`default_nettype wire
